@@ rtl/core/kvc_pkg.sv @@
// Shared constants, types and symbol mapping functions of the keyed Vigenere cipher.
package kvc_pkg;

   localparam int ALPHA_SIZE = 44;
   localparam int SYM_W      = 6;
   localparam logic [SYM_W-1:0] BAD_SYM = 6'd63;

   localparam int KEY_DEPTH  = 32;
   localparam int KEY_POS_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int CSR_DATA_W = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int KEY_CNT_W  = $clog2(KEY_DEPTH + 1);
   localparam int LEN_W      = (KEY_CNT_W > CSR_DATA_W) ? KEY_CNT_W : CSR_DATA_W;

   localparam logic [1:0] CMD_LOAD_ROW = 2'd0;
   localparam logic [1:0] CMD_LOAD_KEY = 2'd1;
   localparam logic [1:0] CMD_CIPHER   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_SPAN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE = 2'd1;

   typedef struct packed {
      logic             en;
      logic [SYM_W-1:0] slot;
      logic [SYM_W-1:0] sym;
   } row_wr_type;

   // Upper-case a byte and map it to its alphabet index, BAD_SYM when absent.
   function automatic logic [SYM_W-1:0] sym_index(input logic [7:0] b);
      logic [7:0]       u;
      logic [SYM_W-1:0] r;
      u = (b inside {[8'h61:8'h7A]}) ? (b - 8'd32) : b;
      case (u) inside
         [8'h41:8'h5A]: r = SYM_W'(u - 8'h41);
         [8'h30:8'h39]: r = SYM_W'(u - 8'h30 + 8'd26);
         8'h20:         r = 6'd36;
         8'h2E:         r = 6'd37;
         8'h2C:         r = 6'd38;
         8'h3B:         r = 6'd39;
         8'h21:         r = 6'd40;
         8'h2D:         r = 6'd41;
         8'h27:         r = 6'd42;
         8'h3F:         r = 6'd43;
         default:       r = BAD_SYM;
      endcase
      return r;
   endfunction

   // Alphabet index back to its byte; indexes past the alphabet give the first symbol.
   function automatic logic [7:0] sym_char(input logic [SYM_W-1:0] i);
      logic [7:0] c;
      case (i) inside
         [6'd0:6'd25]:  c = 8'h41 + {2'b00, i};
         [6'd26:6'd35]: c = 8'h30 + {2'b00, i} - 8'd26;
         6'd36:         c = 8'h20;
         6'd37:         c = 8'h2E;
         6'd38:         c = 8'h2C;
         6'd39:         c = 8'h3B;
         6'd40:         c = 8'h21;
         6'd41:         c = 8'h2D;
         6'd42:         c = 8'h27;
         6'd43:         c = 8'h3F;
         default:       c = 8'h41;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/core/kvc_row_tables.sv @@
// Shuffled row alphabet and its inverse, one write port and one registered read each.
module kvc_row_tables (
   input  logic                       clock,
   input  kvc_pkg::row_wr_type        wr,
   input  logic                       rd_en,
   input  logic [kvc_pkg::SYM_W-1:0]  enc_addr,
   input  logic [kvc_pkg::SYM_W-1:0]  inv_addr,
   output logic [kvc_pkg::SYM_W-1:0]  enc_sym,
   output logic [kvc_pkg::SYM_W-1:0]  inv_pos
);
   import kvc_pkg::*;

   logic [SYM_W-1:0] row_ff [ALPHA_SIZE];
   logic [SYM_W-1:0] inv_ff [ALPHA_SIZE];
   logic [SYM_W-1:0] enc_sym_ff;
   logic [SYM_W-1:0] inv_pos_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         row_ff[wr.slot] <= wr.sym;
         inv_ff[wr.sym]  <= wr.slot;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         enc_sym_ff <= row_ff[enc_addr];
         inv_pos_ff <= inv_ff[inv_addr];
      end
   end

   assign enc_sym = enc_sym_ff;
   assign inv_pos = inv_pos_ff;

endmodule

@@ rtl/core/keyed_vigenere_cipher.sv @@
// Keyed Vigenere cipher top level: input register, row table lookup and result register.
// Usage: the block takes one word per cycle while req_stall is low and puts the result of a
// cipher word on the result ports after it passes the input register, the row table read
// register and the result register; the key table lookup, the key position update and the
// modular add sit between the input register and the row table read. Load words (row entry,
// key character) give no result. Row and key tables come up undefined and must be loaded
// before they are used; there is no clearing pass after reset. Write the key span and decrypt
// mode registers only while no word is in flight.
module keyed_vigenere_cipher (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_cmd,
   input  logic [5:0]                     req_slot,
   input  logic [7:0]                     req_char_in,
   input  logic                           req_first,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_char_out,
   output logic                           rsp_bad_char,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kvc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kvc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import kvc_pkg::*;

   localparam logic [SYM_W:0] ALPHA_EXT = (SYM_W + 1)'(ALPHA_SIZE);

   // configuration
   logic [CSR_DATA_W-1:0] key_span_ff;
   logic                  decrypt_mode_ff;

   // input register
   logic             a_valid_ff;
   logic [1:0]       a_cmd_ff;
   logic [5:0]       a_slot_ff;
   logic [7:0]       a_char_ff;
   logic             a_first_ff;

   // lookup register
   logic             b_valid_ff;
   logic             b_bad_ff;
   logic [SYM_W-1:0] b_k_ff;

   // result register
   logic             rsp_valid_ff;
   logic [7:0]       rsp_char_ff;
   logic             rsp_bad_ff;

   logic [SYM_W-1:0]     key_tab_ff [KEY_DEPTH];
   logic [KEY_POS_W-1:0] key_pos_ff;
   logic [KEY_POS_W-1:0] key_pos_in;

   logic ready_a, ready_b, ready_c, adv_a;

   logic [LEN_W-1:0]  len_raw, len_eff, pos_ext, pos_inc;
   logic [KEY_POS_W-1:0] pos;
   logic [SYM_W-1:0]  a_p, a_k;
   logic              a_bad;
   logic [SYM_W:0]    enc_sum;
   logic [SYM_W-1:0]  enc_addr, inv_addr;
   row_wr_type        row_wr;

   logic [SYM_W-1:0]  enc_sym, inv_pos;
   logic [SYM_W:0]    dec_diff;
   logic [SYM_W-1:0]  dec_sym, res_sym;

   // handshake: each stage takes a word when it is empty or its word moves on
   assign ready_c   = !rsp_valid_ff || !rsp_stall;
   assign ready_b   = !b_valid_ff || ready_c;
   assign ready_a   = !a_valid_ff || ready_b;
   assign adv_a     = a_valid_ff && ready_b;
   assign req_stall = !ready_a;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_span_ff     <= CSR_DATA_W'(1);
         decrypt_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY_SPAN:     key_span_ff     <= csr_wdata;
            CSR_DECRYPT_MODE: decrypt_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (ready_a) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && ready_a) begin
         a_cmd_ff   <= req_cmd;
         a_slot_ff  <= req_slot;
         a_char_ff  <= req_char_in;
         a_first_ff <= req_first;
      end
   end

   // key position: clamp the length, restart on first, wrap at the length
   always_comb begin
      len_raw = LEN_W'(key_span_ff);
      if (len_raw == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_raw > LEN_W'(KEY_DEPTH)) begin
         len_eff = LEN_W'(KEY_DEPTH);
      end else begin
         len_eff = len_raw;
      end
      pos_ext = a_first_ff ? '0 : LEN_W'(key_pos_ff);
      if (pos_ext >= len_eff) begin
         pos_ext = '0;
      end
      pos     = pos_ext[KEY_POS_W-1:0];
      pos_inc = pos_ext + LEN_W'(1);
      key_pos_in = (pos_inc >= len_eff) ? '0 : pos_inc[KEY_POS_W-1:0];
   end

   assign a_p   = sym_index(a_char_ff);
   assign a_k   = key_tab_ff[pos];
   assign a_bad = (a_p == BAD_SYM) || (a_k >= SYM_W'(ALPHA_SIZE));

   always_comb begin
      enc_sum = {1'b0, a_p} + {1'b0, a_k};
      if (enc_sum >= ALPHA_EXT) begin
         enc_sum = enc_sum - ALPHA_EXT;
      end
      // hold addresses inside the table when the word is bad
      enc_addr = a_bad ? '0 : enc_sum[SYM_W-1:0];
      inv_addr = a_bad ? '0 : a_p;
   end

   always_comb begin
      row_wr.en   = adv_a && (a_cmd_ff == CMD_LOAD_ROW) && (a_p != BAD_SYM)
                    && (a_slot_ff < SYM_W'(ALPHA_SIZE));
      row_wr.slot = a_slot_ff;
      row_wr.sym  = a_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff <= '0;
      end else if (adv_a && (a_cmd_ff == CMD_CIPHER)) begin
         key_pos_ff <= key_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a && (a_cmd_ff == CMD_LOAD_KEY) && ({1'b0, a_slot_ff} < 7'(KEY_DEPTH))) begin
         key_tab_ff[a_slot_ff[KEY_POS_W-1:0]] <= a_p;
      end
   end

   kvc_row_tables u_row_tables (
      .clock    (clock),
      .wr       (row_wr),
      .rd_en    (ready_b),
      .enc_addr (enc_addr),
      .inv_addr (inv_addr),
      .enc_sym  (enc_sym),
      .inv_pos  (inv_pos)
   );

   // drop load words here: only cipher words move on
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (ready_b) begin
         b_valid_ff <= a_valid_ff && (a_cmd_ff == CMD_CIPHER);
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b) begin
         b_bad_ff <= a_bad;
         b_k_ff   <= a_k;
      end
   end

   always_comb begin
      dec_diff = {1'b0, inv_pos} + ALPHA_EXT - {1'b0, b_k_ff};
      if (dec_diff >= ALPHA_EXT) begin
         dec_diff = dec_diff - ALPHA_EXT;
      end
      dec_sym = dec_diff[SYM_W-1:0];
      res_sym = decrypt_mode_ff ? dec_sym : enc_sym;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready_c) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_c && b_valid_ff) begin
         rsp_char_ff <= b_bad_ff ? 8'h00 : sym_char(res_sym);
         rsp_bad_ff  <= b_bad_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_bad_char = rsp_bad_ff;

`ifndef SYNTHESIS
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && ready_b && (a_cmd_ff != CMD_CIPHER)) |=> !b_valid_ff)
      else $error("load word reached the lookup stage");

   a_row_write_range: assert property (@(posedge clock) disable iff (reset)
      row_wr.en |-> ((row_wr.slot < SYM_W'(ALPHA_SIZE)) && (row_wr.sym < SYM_W'(ALPHA_SIZE))))
      else $error("row table write outside the alphabet");

   a_good_key_range: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_bad_ff) |-> (b_k_ff < SYM_W'(ALPHA_SIZE)))
      else $error("good word carries a key index outside the alphabet");
`endif

endmodule

@@ tb/kvc_tb_pkg.sv @@
// Alphabet helpers shared by the cipher testbench and its checker.
package kvc_tb_pkg;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [8*kvc_pkg::ALPHA_SIZE-1:0] SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 .,;!-'?";

   function automatic logic [7:0] glyph(input int i);
      return SYMBOLS[8*(kvc_pkg::ALPHA_SIZE-1-i) +: 8];
   endfunction

   // Fold lower case, then search the alphabet; 63 marks a byte outside it.
   function automatic logic [kvc_pkg::SYM_W-1:0] symbol_of(input logic [7:0] b);
      logic [7:0] u;
      u = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
      for (int i = 0; i < kvc_pkg::ALPHA_SIZE; i++) begin
         if (glyph(i) == u) return kvc_pkg::SYM_W'(i);
      end
      return kvc_pkg::BAD_SYM;
   endfunction

endpackage

@@ tb/kvc_checker.sv @@
// Checker: tracks cipher tables and key state, predicts each result word and compares it.
module kvc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_cmd,
   input  logic [5:0]                     req_slot,
   input  logic [7:0]                     req_char_in,
   input  logic                           req_first,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [7:0]                     rsp_char_out,
   input  logic                           rsp_bad_char,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [kvc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kvc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending,
   output int                             cipher_count,
   output int                             bad_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import kvc_pkg::*;
   import kvc_tb_pkg::*;

   typedef struct packed {
      logic [7:0] char_out;
      logic       bad_char;
   } cipher_word_type;

   logic [SYM_W-1:0] row_sym    [ALPHA_SIZE];
   logic [SYM_W-1:0] row_pos_of [ALPHA_SIZE];
   logic [SYM_W-1:0] key_sym    [KEY_DEPTH];
   int               key_pos;
   int               key_len;
   logic             decrypt;
   cipher_word_type  cipher_q[$];

   // Run one cipher word through the key schedule and the row tables.
   function automatic cipher_word_type predict_cipher(input logic [7:0] b,
                                                      input logic restart);
      cipher_word_type w;
      int len, pos, p, k, r;
      len = (key_len == 0) ? 1 : ((key_len > KEY_DEPTH) ? KEY_DEPTH : key_len);
      pos = restart ? 0 : key_pos;
      if (pos >= len) pos = 0;
      k = int'(key_sym[pos]);
      key_pos = (pos + 1 >= len) ? 0 : pos + 1;
      p = int'(symbol_of(b));
      if (p == int'(BAD_SYM) || k >= ALPHA_SIZE) begin
         w.char_out = 8'h00;
         w.bad_char = 1'b1;
      end else begin
         if (!decrypt) r = int'(row_sym[(p + k) % ALPHA_SIZE]);
         else r = (int'(row_pos_of[p]) + ALPHA_SIZE - k) % ALPHA_SIZE;
         if (r >= ALPHA_SIZE) r = 0;
         w.char_out = glyph(r);
         w.bad_char = 1'b0;
      end
      return w;
   endfunction

   task automatic mismatch(input string field, input int want, input int got);
      fail_count++;
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
   endtask

   always @(posedge clock) begin
      cipher_word_type want;
      logic [SYM_W-1:0] s;
      if (reset) begin
         key_pos = 0;
         key_len = 1;
         decrypt = 1'b0;
         cipher_q.delete();
         pending = 0;
         fail_count = 0;
         cipher_count = 0;
         bad_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_SPAN:     key_len = int'(csr_wdata);
               CSR_DECRYPT_MODE: decrypt = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            cipher_count++;
            if (rsp_bad_char) bad_count++;
            if (cipher_q.size() == 0) begin
               fail_count++;
               $error("result word with none expected: char_out %0h bad_char %0b",
                      rsp_char_out, rsp_bad_char);
            end else begin
               want = cipher_q.pop_front();
               if (rsp_char_out !== want.char_out)
                  mismatch("char_out", want.char_out, rsp_char_out);
               if (rsp_bad_char !== want.bad_char)
                  mismatch("bad_char", want.bad_char, rsp_bad_char);
            end
         end
         if (req_valid && !req_stall) begin
            case (req_cmd)
               CMD_LOAD_ROW: begin
                  s = symbol_of(req_char_in);
                  if (req_slot < ALPHA_SIZE && s != BAD_SYM) begin
                     row_sym[req_slot] = s;
                     row_pos_of[s] = req_slot;
                  end
               end
               CMD_LOAD_KEY: begin
                  if (req_slot < KEY_DEPTH)
                     key_sym[req_slot[KEY_POS_W-1:0]] = symbol_of(req_char_in);
               end
               CMD_CIPHER: cipher_q.push_back(predict_cipher(req_char_in, req_first));
               default: ;
            endcase
         end
         pending = cipher_q.size();
      end
   end

endmodule

@@ tb/keyed_vigenere_cipher_tb.sv @@
// Testbench top: drives cipher, load and register words into the block and gives the verdict.
module keyed_vigenere_cipher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kvc_pkg::*;
   import kvc_tb_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int SEGMENT_WORDS = 195;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_cmd;
   logic [5:0]            req_slot;
   logic [7:0]            req_char_in;
   logic                  req_first;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_char_out;
   logic                  rsp_bad_char;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   int tx_idle_pct = 17;
   int rx_idle_pct = 85;
   int words_sent  = 0;
   int reg_writes  = 0;
   int fail_count;
   int pending;
   int cipher_count;
   int bad_count;

   keyed_vigenere_cipher dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_slot     (req_slot),
      .req_char_in  (req_char_in),
      .req_first    (req_first),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_bad_char (rsp_bad_char),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   kvc_checker cipher_chk (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_slot     (req_slot),
      .req_char_in  (req_char_in),
      .req_first    (req_first),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_bad_char (rsp_bad_char),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .cipher_count (cipher_count),
      .bad_count    (bad_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Register the handshakes so the falling-edge driver sees settled values.
   always @(posedge clock) begin
      req_fire <= req_valid && !req_stall;
      rsp_fire <= rsp_valid && !rsp_stall;
      csr_fire <= csr_valid && csr_ready;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(negedge clock);
         if (reset || req_fire || rsp_fire || csr_fire) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Randomly turn letters to lower case.
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1) == 1) return c + 8'd32;
      return c;
   endfunction

   function automatic logic [7:0] pick_char(input int bad_pct);
      if ($urandom_range(99) < bad_pct) return 8'($urandom_range(255));
      return fold_case(glyph($urandom_range(ALPHA_SIZE-1)));
   endfunction

   // Enter at a falling edge; return at the falling edge after the word is taken.
   task automatic send_word(input logic [1:0] cmd, input logic [5:0] slot,
                            input logic [7:0] ch, input logic restart);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_slot    <= slot;
      req_char_in <= ch;
      req_first   <= restart;
      do @(negedge clock); while (!req_fire);
      words_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
      @(negedge clock);
      reg_writes++;
   endtask

   // Drop valid, wait out every expected result and the load words still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Load a fresh random permutation into the row alphabet.
   task automatic load_rows();
      int order [ALPHA_SIZE];
      int i, j, t;
      for (i = 0; i < ALPHA_SIZE; i++) order[i] = i;
      for (i = ALPHA_SIZE - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (i = 0; i < ALPHA_SIZE; i++)
         send_word(CMD_LOAD_ROW, 6'(i), fold_case(glyph(order[i])), 1'($urandom));
   endtask

   task automatic random_segment(input int count);
      int n, roll;
      logic [5:0] slot;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         slot = ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(ALPHA_SIZE-1));
         if (roll < 74)
            send_word(CMD_CIPHER, 6'($urandom), pick_char(15), $urandom_range(9) == 0);
         else if (roll < 85)
            send_word(CMD_LOAD_ROW, slot, pick_char(10), 1'($urandom));
         else if (roll < 96)
            send_word(CMD_LOAD_KEY, slot, pick_char(10), 1'($urandom));
         else
            send_word(CMD_UNUSED, 6'($urandom), 8'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      int phase, seg, i;
      logic [CSR_DATA_W-1:0] len;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_LOAD_ROW;
      req_slot    = 6'd0;
      req_char_in = 8'h00;
      req_first   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = CSR_KEY_SPAN;
      csr_wdata   = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Fill every table entry before any cipher word reads one.
      load_rows();
      for (i = 0; i < KEY_DEPTH; i++) send_word(CMD_LOAD_KEY, 6'(i), pick_char(0), 1'b0);
      settle();
      write_reg(CSR_KEY_SPAN, 6'd32);
      write_reg(CSR_DECRYPT_MODE, 6'b111110);

      send_word(CMD_CIPHER, 6'd0, "A", 1'b1);
      send_word(CMD_CIPHER, 6'd63, "z", 1'b0);
      send_word(CMD_CIPHER, 6'd17, "?", 1'b0);
      send_word(CMD_CIPHER, 6'd0, " ", 1'b0);
      send_word(CMD_CIPHER, 6'd0, 8'h00, 1'b0);
      send_word(CMD_CIPHER, 6'd0, 8'hFF, 1'b0);
      send_word(CMD_CIPHER, 6'd0, 8'h7B, 1'b0);
      send_word(CMD_CIPHER, 6'd0, 8'h60, 1'b1);
      send_word(CMD_UNUSED, 6'd5, "B", 1'b1);
      send_word(CMD_LOAD_ROW, 6'd63, "A", 1'b0);
      send_word(CMD_LOAD_ROW, 6'd44, "B", 1'b0);
      send_word(CMD_LOAD_ROW, 6'd0, "#", 1'b0);
      send_word(CMD_LOAD_KEY, 6'd32, "C", 1'b0);
      // Poison key slot 2 and walk onto it.
      send_word(CMD_LOAD_KEY, 6'd2, "#", 1'b0);
      send_word(CMD_CIPHER, 6'd0, "0", 1'b1);
      send_word(CMD_CIPHER, 6'd0, "9", 1'b0);
      send_word(CMD_CIPHER, 6'd0, "-", 1'b0);
      send_word(CMD_LOAD_KEY, 6'd2, pick_char(0), 1'b0);
      send_word(CMD_CIPHER, 6'd0, "'", 1'b0);
      // Key position is now past the shorter length below.
      settle();
      write_reg(CSR_KEY_SPAN, 6'd3);
      send_word(CMD_CIPHER, 6'd0, "M", 1'b0);
      settle();
      write_reg(CSR_KEY_SPAN, 6'd0);
      write_reg(CSR_DECRYPT_MODE, 6'd1);
      send_word(CMD_CIPHER, 6'd0, "Q", 1'b0);
      send_word(CMD_CIPHER, 6'd0, "q", 1'b0);
      // Duplicate a symbol in the row alphabet, then decrypt it.
      send_word(CMD_LOAD_ROW, 6'd1, "K", 1'b0);
      send_word(CMD_CIPHER, 6'd0, "K", 1'b0);

      for (phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 17 : ((phase == 1) ? 85 : 0);
         rx_idle_pct = (phase == 0) ? 85 : ((phase == 1) ? 17 : 0);
         load_rows();
         for (seg = 0; seg < 2; seg++) begin
            case (phase * 2 + seg)
               0:       len = 6'd32;
               1:       len = 6'd1;
               2:       len = 6'd63;
               3:       len = 6'd0;
               4:       len = 6'($urandom_range(2, 31));
               default: len = 6'd33;
            endcase
            settle();
            write_reg(CSR_KEY_SPAN, len);
            write_reg(CSR_DECRYPT_MODE, {5'($urandom), 1'(seg ^ phase)});
            random_segment(SEGMENT_WORDS);
         end
      end
      settle();

      $display("covered %0d input words and %0d register writes over three idling phases",
               words_sent, reg_writes);
      $display("checked %0d cipher results, %0d of them flagged as bad characters",
               cipher_count, bad_count);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ keyed_vigenere_cipher.f @@
rtl/core/kvc_pkg.sv
rtl/core/kvc_row_tables.sv
rtl/core/keyed_vigenere_cipher.sv
tb/kvc_tb_pkg.sv
tb/kvc_checker.sv
tb/keyed_vigenere_cipher_tb.sv
